@@ rtl/core/csq_pkg.sv @@
// ============================================================================
// csq_pkg: shared types and constants of the coalescing signal queue
// Sizes, command and status codes, and the structs that pass between the
// slot table, the link queue and the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

    // Sizes of the slot table and of the beat fields.
    localparam int NUM_SIGNALS  = 16;
    localparam int ARG_BITS     = 32;
    localparam int HANDLER_BITS = 8;
    localparam int ID_BITS      = 4;
    localparam int KIND_BITS    = 3;
    localparam int STATUS_BITS  = 2;
    localparam int SLOT_BITS    = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;

    // Command codes carried in the kind field.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_CREATE  = 3'd0,
        KIND_DELETE  = 3'd1,
        KIND_SEND    = 3'd2,
        KIND_SET_HND = 3'd3,
        KIND_QUERY   = 3'd4,
        KIND_PROCESS = 3'd5
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK          = 2'd0,
        ST_INV_OBJ     = 2'd1,
        ST_INV_HANDLER = 2'd2,
        ST_RAISED      = 2'd3
    } status_t;

    // Write request into the slot table; one slot per cycle.
    typedef struct packed {
        logic                    en;
        logic                    set_live;
        logic                    clr_live;
        logic                    set_raised;
        logic                    clr_raised;
        logic                    wr_handler;
        logic                    wr_arg;
        logic [SLOT_BITS-1:0]    addr;
        logic [HANDLER_BITS-1:0] handler;
        logic [ARG_BITS-1:0]     arg;
    } slot_wr_t;

    // Values read from the slot table for the addressed slot and the head.
    typedef struct packed {
        logic                    live_s;
        logic                    raised_s;
        logic                    raised_head;
        logic [HANDLER_BITS-1:0] handler_head;
        logic [ARG_BITS-1:0]     arg_head;
    } slot_rd_t;

    // Request into the link queue: append one slot or unlink one slot.
    typedef struct packed {
        logic                 en;
        logic                 append;
        logic                 unlink;
        logic [SLOT_BITS-1:0] append_slot;
        logic [SLOT_BITS-1:0] unlink_slot;
    } queue_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/csq_slot_table.sv @@
// ============================================================================
// csq_slot_table: per-slot flags, handlers and arguments
// Live and raised flags reset to zero; handler and argument entries hold
// whatever was last written. Reads are combinational.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module csq_slot_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csq_pkg::slot_wr_t             wr,
    input  wire logic [csq_pkg::SLOT_BITS-1:0] rd_slot,
    input  wire logic [csq_pkg::SLOT_BITS-1:0] rd_head,
    output csq_pkg::slot_rd_t                  rd
);

    logic [csq_pkg::NUM_SIGNALS-1:0]  live_reg;
    logic [csq_pkg::NUM_SIGNALS-1:0]  live_next;
    logic [csq_pkg::NUM_SIGNALS-1:0]  raised_reg;
    logic [csq_pkg::NUM_SIGNALS-1:0]  raised_next;
    logic [csq_pkg::HANDLER_BITS-1:0] handler_reg [csq_pkg::NUM_SIGNALS];
    logic [csq_pkg::ARG_BITS-1:0]     arg_reg     [csq_pkg::NUM_SIGNALS];

    // Flag updates for the single addressed slot.
    always_comb
    begin
        live_next   = live_reg;
        raised_next = raised_reg;
        if (wr.en)
        begin
            if (wr.set_live)
                live_next[wr.addr] = 1'b1;
            if (wr.clr_live)
                live_next[wr.addr] = 1'b0;
            if (wr.set_raised)
                raised_next[wr.addr] = 1'b1;
            if (wr.clr_raised)
                raised_next[wr.addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            raised_reg <= '0;
        end
        else
        begin
            live_reg   <= live_next;
            raised_reg <= raised_next;
        end
    end

    // Handler and argument storage, no reset.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.wr_handler)
            handler_reg[wr.addr] <= wr.handler;
        if (wr.en && wr.wr_arg)
            arg_reg[wr.addr] <= wr.arg;
    end

    // Read side for the addressed slot and the queue head.
    always_comb
    begin
        rd.live_s       = live_reg[rd_slot];
        rd.raised_s     = raised_reg[rd_slot];
        rd.raised_head  = raised_reg[rd_head];
        rd.handler_head = handler_reg[rd_head];
        rd.arg_head     = arg_reg[rd_head];
    end

`ifndef NO_ASSERTIONS
    // A raised slot is always a live slot.
    a_raised_is_live: assert property (@(posedge clk) disable iff (!rst_n)
        (raised_reg & ~live_reg) == '0)
        else $error("raised flag set on a deleted slot");
`endif

endmodule

`default_nettype wire

@@ rtl/core/csq_link_queue.sv @@
// ============================================================================
// csq_link_queue: doubly linked FIFO over the signal slots
// Holds head, tail, empty flag and the next and previous links. Takes one
// append or one unlink per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module csq_link_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csq_pkg::queue_cmd_t           cmd,
    output logic [csq_pkg::SLOT_BITS-1:0]      head,
    output logic                               empty
);

    logic [csq_pkg::SLOT_BITS-1:0] next_link_reg [csq_pkg::NUM_SIGNALS];
    logic [csq_pkg::SLOT_BITS-1:0] prev_link_reg [csq_pkg::NUM_SIGNALS];
    logic [csq_pkg::SLOT_BITS-1:0] head_reg;
    logic [csq_pkg::SLOT_BITS-1:0] head_next;
    logic [csq_pkg::SLOT_BITS-1:0] tail_reg;
    logic [csq_pkg::SLOT_BITS-1:0] tail_next;
    logic                          empty_reg;
    logic                          empty_next;

    logic                          nl_we;
    logic [csq_pkg::SLOT_BITS-1:0] nl_addr;
    logic [csq_pkg::SLOT_BITS-1:0] nl_data;
    logic                          pl_we;
    logic [csq_pkg::SLOT_BITS-1:0] pl_addr;
    logic [csq_pkg::SLOT_BITS-1:0] pl_data;
    logic [csq_pkg::SLOT_BITS-1:0] u_next;
    logic [csq_pkg::SLOT_BITS-1:0] u_prev;

    assign u_next = next_link_reg[cmd.unlink_slot];
    assign u_prev = prev_link_reg[cmd.unlink_slot];

    // Pointer and link updates for an append or an unlink.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        nl_we      = 1'b0;
        nl_addr    = tail_reg;
        nl_data    = cmd.append_slot;
        pl_we      = 1'b0;
        pl_addr    = cmd.append_slot;
        pl_data    = tail_reg;
        if (cmd.en && cmd.append)
        begin
            if (empty_reg)
            begin
                head_next  = cmd.append_slot;
                tail_next  = cmd.append_slot;
                empty_next = 1'b0;
            end
            else
            begin
                nl_we     = 1'b1;
                pl_we     = 1'b1;
                tail_next = cmd.append_slot;
            end
        end
        else if (cmd.en && cmd.unlink && !empty_reg)
        begin
            priority if (cmd.unlink_slot == head_reg && cmd.unlink_slot == tail_reg)
            begin
                empty_next = 1'b1;
            end
            else if (cmd.unlink_slot == head_reg)
            begin
                head_next = u_next;
            end
            else if (cmd.unlink_slot == tail_reg)
            begin
                tail_next = u_prev;
            end
            else
            begin
                // Middle entry: bridge its neighbors.
                nl_we   = 1'b1;
                nl_addr = u_prev;
                nl_data = u_next;
                pl_we   = 1'b1;
                pl_addr = u_next;
                pl_data = u_prev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    // Link storage, no reset.
    always_ff @(posedge clk)
    begin
        if (nl_we)
            next_link_reg[nl_addr] <= nl_data;
        if (pl_we)
            prev_link_reg[pl_addr] <= pl_data;
    end

    assign head  = head_reg;
    assign empty = empty_reg;

`ifndef NO_ASSERTIONS
    // Append and unlink never arrive in the same cycle.
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.en |-> !(cmd.append && cmd.unlink))
        else $error("append and unlink requested together");
`endif

endmodule

`default_nettype wire

@@ rtl/core/coalescing_signal_queue.sv @@
// ============================================================================
// coalescing_signal_queue: signal slot table with a coalescing FIFO
// Create, delete, send, set handler, query and process commands on a table
// of signal slots; raised slots are delivered in first-in first-out order.
// ============================================================================
//
//   Channel   Handshake              Beat contents
//   command   cmd_valid/cmd_ready    kind, signal_id, handler_id, arg_value
//   result    rsp_valid/rsp_ready    status, raised, delivered, out_signal,
//                                    out_handler, out_arg
//
// One command beat is taken per cycle unless a held result stalls the block;
// its result beat passes through the command register, then the result register.
// The command is executed, and the slot table and link queue updated, in the
// single cycle it moves from the command register to the result register.
// Reset clears all live and raised flags and empties the queue.
// A held result stalls execution; the command register still takes one beat.
//
`timescale 1ns / 1ps
`default_nettype none

module coalescing_signal_queue (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire logic [csq_pkg::KIND_BITS-1:0]    kind,
    input  wire logic [csq_pkg::ID_BITS-1:0]      signal_id,
    input  wire logic [csq_pkg::HANDLER_BITS-1:0] handler_id,
    input  wire logic [csq_pkg::ARG_BITS-1:0]     arg_value,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic [csq_pkg::STATUS_BITS-1:0]       status,
    output logic                                  raised,
    output logic                                  delivered,
    output logic [csq_pkg::ID_BITS-1:0]           out_signal,
    output logic [csq_pkg::HANDLER_BITS-1:0]      out_handler,
    output logic [csq_pkg::ARG_BITS-1:0]          out_arg
);

    // Command register.
    logic                             cmd_v_reg;
    logic [csq_pkg::KIND_BITS-1:0]    kind_reg;
    logic [csq_pkg::ID_BITS-1:0]      id_reg;
    logic [csq_pkg::HANDLER_BITS-1:0] hnd_reg;
    logic [csq_pkg::ARG_BITS-1:0]     arg_reg;

    // Result register.
    logic                             rsp_v_reg;
    logic [csq_pkg::STATUS_BITS-1:0]  status_reg;
    logic                             raised_reg;
    logic                             deliv_reg;
    logic [csq_pkg::ID_BITS-1:0]      osig_reg;
    logic [csq_pkg::HANDLER_BITS-1:0] ohnd_reg;
    logic [csq_pkg::ARG_BITS-1:0]     oarg_reg;

    // Result of the command being executed.
    csq_pkg::status_t                 status_next;
    logic                             raised_next;
    logic                             deliv_next;
    logic [csq_pkg::ID_BITS-1:0]      osig_next;
    logic [csq_pkg::HANDLER_BITS-1:0] ohnd_next;
    logic [csq_pkg::ARG_BITS-1:0]     oarg_next;

    logic                             advance;
    logic                             id_ok;
    logic [csq_pkg::SLOT_BITS-1:0]    slot;
    logic                             live_s;
    logic                             hnd_zero;
    logic [csq_pkg::SLOT_BITS-1:0]    q_head;
    logic                             q_empty;

    csq_pkg::slot_wr_t                slot_wr;
    csq_pkg::slot_rd_t                slot_rd;
    csq_pkg::queue_cmd_t              q_cmd;

    // Pipeline flow control.
    assign advance   = cmd_v_reg && (!rsp_v_reg || rsp_ready);
    assign cmd_ready = !cmd_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_v_reg <= 1'b0;
            rsp_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
                cmd_v_reg <= cmd_valid;
            if (advance)
                rsp_v_reg <= 1'b1;
            else if (rsp_ready)
                rsp_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            kind_reg <= kind;
            id_reg   <= signal_id;
            hnd_reg  <= handler_id;
            arg_reg  <= arg_value;
        end
        if (advance)
        begin
            status_reg <= status_next;
            raised_reg <= raised_next;
            deliv_reg  <= deliv_next;
            osig_reg   <= osig_next;
            ohnd_reg   <= ohnd_next;
            oarg_reg   <= oarg_next;
        end
    end

    // Slot addressing: out-of-range ids act as a deleted slot.
    assign id_ok    = (32'(id_reg) < 32'(csq_pkg::NUM_SIGNALS));
    assign slot     = id_ok ? csq_pkg::SLOT_BITS'(id_reg) : '0;
    assign live_s   = id_ok && slot_rd.live_s;
    assign hnd_zero = (hnd_reg == '0);

    // Command decode and execution.
    always_comb
    begin
        status_next        = csq_pkg::ST_OK;
        raised_next        = 1'b0;
        deliv_next         = 1'b0;
        osig_next          = '0;
        ohnd_next          = '0;
        oarg_next          = '0;

        slot_wr            = '0;
        slot_wr.en         = advance;
        slot_wr.addr       = slot;
        slot_wr.handler    = hnd_reg;
        slot_wr.arg        = arg_reg;

        q_cmd              = '0;
        q_cmd.en           = advance;
        q_cmd.append_slot  = slot;
        q_cmd.unlink_slot  = slot;

        unique case (csq_pkg::kind_t'(kind_reg))
            csq_pkg::KIND_CREATE:
            begin
                if (hnd_zero)
                    status_next = csq_pkg::ST_INV_HANDLER;
                else if (!id_ok || live_s)
                    status_next = csq_pkg::ST_INV_OBJ;
                else
                begin
                    slot_wr.set_live   = 1'b1;
                    slot_wr.clr_raised = 1'b1;
                    slot_wr.wr_handler = 1'b1;
                end
            end
            csq_pkg::KIND_DELETE:
            begin
                if (!live_s)
                    status_next = csq_pkg::ST_INV_OBJ;
                else
                begin
                    slot_wr.clr_live   = 1'b1;
                    slot_wr.clr_raised = 1'b1;
                    q_cmd.unlink       = slot_rd.raised_s;
                end
            end
            csq_pkg::KIND_SEND:
            begin
                if (!live_s)
                    status_next = csq_pkg::ST_INV_OBJ;
                else if (slot_rd.raised_s)
                    status_next = csq_pkg::ST_RAISED;
                else
                begin
                    slot_wr.set_raised = 1'b1;
                    slot_wr.wr_arg     = 1'b1;
                    q_cmd.append       = 1'b1;
                end
            end
            csq_pkg::KIND_SET_HND:
            begin
                if (hnd_zero)
                    status_next = csq_pkg::ST_INV_HANDLER;
                else if (!live_s)
                    status_next = csq_pkg::ST_INV_OBJ;
                else
                    slot_wr.wr_handler = 1'b1;
            end
            csq_pkg::KIND_QUERY:
            begin
                raised_next = live_s && slot_rd.raised_s;
            end
            csq_pkg::KIND_PROCESS:
            begin
                // Pop the head slot and deliver its handler and argument.
                if (!q_empty && slot_rd.raised_head)
                begin
                    slot_wr.addr       = q_head;
                    slot_wr.clr_raised = 1'b1;
                    q_cmd.unlink       = 1'b1;
                    q_cmd.unlink_slot  = q_head;
                    deliv_next         = 1'b1;
                    osig_next          = csq_pkg::ID_BITS'(q_head);
                    ohnd_next          = slot_rd.handler_head;
                    oarg_next          = slot_rd.arg_head;
                end
            end
            default:
            begin
            end
        endcase
    end

    csq_slot_table u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (slot_wr),
        .rd_slot (slot),
        .rd_head (q_head),
        .rd      (slot_rd)
    );

    csq_link_queue u_link_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .head  (q_head),
        .empty (q_empty)
    );

    assign rsp_valid   = rsp_v_reg;
    assign status      = status_reg;
    assign raised      = raised_reg;
    assign delivered   = deliv_reg;
    assign out_signal  = osig_reg;
    assign out_handler = ohnd_reg;
    assign out_arg     = oarg_reg;

`ifndef NO_ASSERTIONS
    // A nonempty queue always has a raised slot at its head.
    a_head_raised: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> slot_rd.raised_head)
        else $error("queue head slot is not raised");

    // An executed command always lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_v_reg)
        else $error("executed command produced no result");

    // A delivery always reports ok and no query answer.
    a_deliver_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_v_reg && deliv_reg) |-> (status_reg == csq_pkg::ST_OK && !raised_reg))
        else $error("delivery with a non-ok status");

    // State changes only while a command executes.
    a_wr_gated: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> (!slot_wr.en && !q_cmd.en))
        else $error("state write outside execution");
`endif

endmodule

`default_nettype wire

@@ tb/sv/coalescing_signal_queue_test.sv @@
// ============================================================================
// coalescing_signal_queue_test: self-checking bench for the signal queue
// Drives command beats through the valid/ready channel, predicts every result
// beat from a private copy of the slot table and its linked FIFO, and checks
// each result beat field by field. A short table of directed commands comes
// first, then random traffic under four phases of sender and receiver idling.
// ============================================================================
`timescale 1ns / 1ps

module coalescing_signal_queue_test;

    import csq_pkg::*;

    // Kind codes that the block must ignore.
    localparam logic [KIND_BITS-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS   = 1624;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_SEND_GAP   = 12;
    localparam int DRAIN_CYCLES   = 8;

    // One command beat.
    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [ID_BITS-1:0]      signal_id;
        logic [HANDLER_BITS-1:0] handler_id;
        logic [ARG_BITS-1:0]     arg_value;
    } op_t;

    // One result beat.
    typedef struct packed {
        status_t                 status;
        logic                    raised;
        logic                    delivered;
        logic [ID_BITS-1:0]      out_signal;
        logic [HANDLER_BITS-1:0] out_handler;
        logic [ARG_BITS-1:0]     out_arg;
    } outcome_t;

    // A directed command, with a typed-in result where one is given.
    typedef struct {
        op_t      op;
        bit       fixed;
        outcome_t want;
    } step_row_t;

    // Clock, reset and block ports.
    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    cmd_valid  = 1'b0;
    logic                    cmd_ready;
    logic [KIND_BITS-1:0]    kind       = '0;
    logic [ID_BITS-1:0]      signal_id  = '0;
    logic [HANDLER_BITS-1:0] handler_id = '0;
    logic [ARG_BITS-1:0]     arg_value  = '0;
    logic                    rsp_valid;
    logic                    rsp_ready  = 1'b0;
    logic [STATUS_BITS-1:0]  status;
    logic                    raised;
    logic                    delivered;
    logic [ID_BITS-1:0]      out_signal;
    logic [HANDLER_BITS-1:0] out_handler;
    logic [ARG_BITS-1:0]     out_arg;

    // Predicted slot table and FIFO links.
    bit                    slot_live    [NUM_SIGNALS];
    bit                    slot_raised  [NUM_SIGNALS];
    bit [HANDLER_BITS-1:0] slot_handler [NUM_SIGNALS];
    bit [ARG_BITS-1:0]     slot_arg     [NUM_SIGNALS];
    bit [SLOT_BITS-1:0]    next_link    [NUM_SIGNALS];
    bit [SLOT_BITS-1:0]    prev_link    [NUM_SIGNALS];
    bit [SLOT_BITS-1:0]    fifo_head;
    bit [SLOT_BITS-1:0]    fifo_tail;
    bit                    fifo_empty = 1'b1;

    // Results still owed by the block, oldest first.
    outcome_t  pending_outcomes [$];
    step_row_t directed_plan [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int deliveries     = 0;
    int stall_cycles   = 0;
    outcome_t got_beat;
    outcome_t want_beat;

    coalescing_signal_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .kind        (kind),
        .signal_id   (signal_id),
        .handler_id  (handler_id),
        .arg_value   (arg_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .raised      (raised),
        .delivered   (delivered),
        .out_signal  (out_signal),
        .out_handler (out_handler),
        .out_arg     (out_arg)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Removes a raised slot from the predicted FIFO.
    function automatic void unlink_slot(int s);
        bit [SLOT_BITS-1:0] p;
        bit [SLOT_BITS-1:0] n;
        p = prev_link[s];
        n = next_link[s];
        if (fifo_empty)
            return;
        if (s == fifo_head && s == fifo_tail)
            fifo_empty = 1'b1;
        else if (s == fifo_head)
            fifo_head = n;
        else if (s == fifo_tail)
            fifo_tail = p;
        else
        begin
            next_link[p] = n;
            prev_link[n] = p;
        end
    endfunction

    // Applies one command to the predicted table and returns its result beat.
    function automatic outcome_t execute_on_table(op_t c);
        outcome_t r;
        bit       in_range;
        bit       live;
        int       s;
        int       q;
        r        = '0;
        r.status = ST_OK;
        in_range = c.signal_id < NUM_SIGNALS;
        s        = in_range ? int'(c.signal_id) : 0;
        live     = in_range && slot_live[s];
        case (c.kind)
            KIND_CREATE:
            begin
                if (c.handler_id == '0)
                    r.status = ST_INV_HANDLER;
                else if (!in_range || live)
                    r.status = ST_INV_OBJ;
                else
                begin
                    slot_live[s]    = 1'b1;
                    slot_raised[s]  = 1'b0;
                    slot_handler[s] = c.handler_id;
                end
            end
            KIND_DELETE:
            begin
                if (!live)
                    r.status = ST_INV_OBJ;
                else
                begin
                    if (slot_raised[s])
                        unlink_slot(s);
                    slot_raised[s] = 1'b0;
                    slot_live[s]   = 1'b0;
                end
            end
            KIND_SEND:
            begin
                if (!live)
                    r.status = ST_INV_OBJ;
                else if (slot_raised[s])
                    r.status = ST_RAISED;
                else
                begin
                    slot_raised[s] = 1'b1;
                    slot_arg[s]    = c.arg_value;
                    // Append at the tail of the FIFO.
                    if (fifo_empty)
                    begin
                        fifo_head  = SLOT_BITS'(s);
                        fifo_tail  = SLOT_BITS'(s);
                        fifo_empty = 1'b0;
                    end
                    else
                    begin
                        next_link[fifo_tail] = SLOT_BITS'(s);
                        prev_link[s]         = fifo_tail;
                        fifo_tail            = SLOT_BITS'(s);
                    end
                end
            end
            KIND_SET_HND:
            begin
                if (c.handler_id == '0)
                    r.status = ST_INV_HANDLER;
                else if (!live)
                    r.status = ST_INV_OBJ;
                else
                    slot_handler[s] = c.handler_id;
            end
            KIND_QUERY:
                r.raised = live && slot_raised[s];
            KIND_PROCESS:
            begin
                q = fifo_head;
                if (!fifo_empty && slot_raised[q])
                begin
                    slot_raised[q] = 1'b0;
                    unlink_slot(q);
                    r.delivered   = 1'b1;
                    r.out_signal  = ID_BITS'(q);
                    r.out_handler = slot_handler[q];
                    r.out_arg     = slot_arg[q];
                    deliveries++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Queues one directed command, with or without a typed-in result.
    function automatic void add_row(logic [KIND_BITS-1:0] k, int id, int h,
                                    logic [ARG_BITS-1:0] a, bit fixed = 1'b0,
                                    status_t st = ST_OK, bit rs = 1'b0);
        step_row_t row;
        row.op.kind       = k;
        row.op.signal_id  = ID_BITS'(id);
        row.op.handler_id = HANDLER_BITS'(h);
        row.op.arg_value  = a;
        row.fixed         = fixed;
        row.want          = '0;
        row.want.status   = st;
        row.want.raised   = rs;
        directed_plan.push_back(row);
    endfunction

    // Presents one command beat, holds it until taken, then records its result.
    task automatic issue(input op_t c, input bit fixed, input outcome_t fixed_want);
        int       gap;
        outcome_t predicted;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        kind       <= c.kind;
        signal_id  <= c.signal_id;
        handler_id <= c.handler_id;
        arg_value  <= c.arg_value;
        do
            @(posedge clk);
        while (!cmd_ready);
        predicted = execute_on_table(c);
        pending_outcomes.push_back(fixed ? fixed_want : predicted);
        beats_sent++;
    endtask

    // Reports one field that differs from its expectation.
    function automatic void check_field(string name, logic [ARG_BITS-1:0] want,
                                        logic [ARG_BITS-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver: random back-pressure and result checking.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got_beat.status      = status_t'(status);
            got_beat.raised      = raised;
            got_beat.delivered   = delivered;
            got_beat.out_signal  = out_signal;
            got_beat.out_handler = out_handler;
            got_beat.out_arg     = out_arg;
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat with no command outstanding");
                mismatch_count++;
            end
            else
            begin
                want_beat = pending_outcomes.pop_front();
                check_field("status", ARG_BITS'(want_beat.status),
                            ARG_BITS'(got_beat.status));
                check_field("raised", ARG_BITS'(want_beat.raised),
                            ARG_BITS'(got_beat.raised));
                check_field("delivered", ARG_BITS'(want_beat.delivered),
                            ARG_BITS'(got_beat.delivered));
                check_field("out_signal", ARG_BITS'(want_beat.out_signal),
                            ARG_BITS'(got_beat.out_signal));
                check_field("out_handler", ARG_BITS'(want_beat.out_handler),
                            ARG_BITS'(got_beat.out_handler));
                check_field("out_arg", want_beat.out_arg, got_beat.out_arg);
                beats_checked++;
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles, %0d results owed",
                     STALL_LIMIT, pending_outcomes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        int                      send_pcts [4];
        int                      recv_pcts [4];
        int                      pick;
        int                      roll;
        bit                      want_live;
        op_t                     c;
        logic [ID_BITS-1:0]      id;
        logic [HANDLER_BITS-1:0] h;
        logic [ARG_BITS-1:0]     a;

        send_pcts = '{0, 58, 0, 25};
        recv_pcts = '{0, 0, 58, 25};

        // Directed commands: empty-table answers, argument checks, every kind,
        // coalescing of a second send, and unlinking at head, middle and tail.
        add_row(KIND_QUERY,   0,  8'h00, 32'h0000_0000, 1, ST_OK, 0);
        add_row(KIND_PROCESS, 0,  8'h00, 32'h0000_0000, 1, ST_OK, 0);
        add_row(KIND_CREATE,  5,  8'h00, 32'h0000_0000, 1, ST_INV_HANDLER, 0);
        add_row(KIND_SET_HND, 3,  8'h07, 32'h0000_0000, 1, ST_INV_OBJ, 0);
        add_row(KIND_SET_HND, 3,  8'h00, 32'h0000_0000, 1, ST_INV_HANDLER, 0);
        add_row(KIND_DELETE,  15, 8'h00, 32'h0000_0000, 1, ST_INV_OBJ, 0);
        add_row(KIND_SEND,    0,  8'h00, 32'hFFFF_FFFF, 1, ST_INV_OBJ, 0);
        add_row(KIND_CREATE,  0,  8'hFF, 32'h0000_0000, 1, ST_OK, 0);
        add_row(KIND_CREATE,  15, 8'h01, 32'h0000_0000, 1, ST_OK, 0);
        add_row(KIND_CREATE,  0,  8'h10, 32'h0000_0000, 1, ST_INV_OBJ, 0);
        add_row(KIND_CREATE,  7,  8'h5A, 32'h0000_0000);
        add_row(KIND_SEND,    0,  8'h00, 32'hFFFF_FFFF, 1, ST_OK, 0);
        add_row(KIND_SEND,    15, 8'h00, 32'h0000_0000);
        add_row(KIND_SEND,    7,  8'h00, 32'hA5A5_A5A5);
        add_row(KIND_SEND,    0,  8'h00, 32'h1234_5678, 1, ST_RAISED, 0);
        add_row(KIND_QUERY,   0,  8'h00, 32'h0000_0000, 1, ST_OK, 1);
        add_row(KIND_DELETE,  15, 8'h00, 32'h0000_0000);
        add_row(KIND_SET_HND, 0,  8'h80, 32'h0000_0000);
        add_row(KIND_PROCESS, 0,  8'h00, 32'h0000_0000);
        add_row(KIND_SEND,    0,  8'h00, 32'h5A5A_5A5A);
        add_row(KIND_DELETE,  0,  8'h00, 32'h0000_0000);
        add_row(KIND_SEND,    0,  8'h00, 32'h0000_0001);
        add_row(KIND_DELETE,  7,  8'h00, 32'h0000_0000);
        add_row(KIND_SPARE_A, 15, 8'hFF, 32'hFFFF_FFFF, 1, ST_OK, 0);
        add_row(KIND_SPARE_B, 9,  8'h33, 32'h0F0F_0F0F, 1, ST_OK, 0);
        add_row(KIND_DELETE,  0,  8'h00, 32'h0000_0000);
        add_row(KIND_PROCESS, 0,  8'h00, 32'h0000_0000, 1, ST_OK, 0);

        // Hold reset, then release on a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            issue(directed_plan[i].op, directed_plan[i].fixed, directed_plan[i].want);

        // Random traffic in four idling phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    c.kind = KIND_CREATE;
                else if (pick < 22)
                    c.kind = KIND_DELETE;
                else if (pick < 52)
                    c.kind = KIND_SEND;
                else if (pick < 60)
                    c.kind = KIND_SET_HND;
                else if (pick < 70)
                    c.kind = KIND_QUERY;
                else if (pick < 97)
                    c.kind = KIND_PROCESS;
                else
                    c.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;

                // Mostly aim at a slot whose state lets the command take effect.
                id        = ID_BITS'($urandom_range(0, NUM_SIGNALS - 1));
                want_live = (c.kind != KIND_CREATE);
                if ($urandom_range(0, 99) < 85)
                    for (int t = 0; t < 16 && slot_live[id] != want_live; t++)
                        id = ID_BITS'($urandom_range(0, NUM_SIGNALS - 1));

                roll = $urandom_range(0, 99);
                if (roll < 5)
                    h = '0;
                else if (roll < 10)
                    h = '1;
                else if (roll < 13)
                    h = 8'h01;
                else
                    h = HANDLER_BITS'($urandom_range(1, 255));

                roll = $urandom_range(0, 99);
                if (roll < 5)
                    a = '0;
                else if (roll < 10)
                    a = '1;
                else
                    a = $urandom;

                c.signal_id  = id;
                c.handler_id = h;
                c.arg_value  = a;
                issue(c, 1'b0, '0);
            end
        end
        cmd_valid <= 1'b0;

        // Drain the outstanding results, then allow for stray beats.
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result beats for %0d commands (%0d directed, the rest random",
                 beats_checked, beats_sent, directed_plan.size());
        $display("over four idling phases); %0d signals were delivered from the FIFO.",
                 deliveries);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
